[rtl/core/bifbs_pkg.sv]
// Shared types, constants and a helper function for the bounded integer decoder.
package bifbs_pkg;

	localparam int unsigned VALUE_W = 64;
	localparam int unsigned POS_W = 4;
	localparam int unsigned LEN_W = 3;
	localparam int unsigned Q_DEPTH = 2;
	localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [POS_W-1:0] ATTEMPT_BYTES = POS_W'(9);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(8);

	localparam logic [VALUE_W-1:0] INT64_MIN_BITS = 64'h8000_0000_0000_0000;
	localparam logic [VALUE_W-1:0] INT64_MAX_BITS = 64'h7fff_ffff_ffff_ffff;
	localparam logic [VALUE_W-1:0] LOWER_RESET = 64'd0;
	localparam logic [VALUE_W-1:0] UPPER_RESET = 64'd255;

	localparam logic REG_LOWER = 1'b0;
	localparam logic REG_UPPER = 1'b1;

	localparam logic [1:0] KIND_EQUAL = 2'd0;
	localparam logic [1:0] KIND_END = 2'd1;
	localparam logic [1:0] KIND_JUDGE = 2'd2;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_OUT_OF_DATA = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_data;
	} byte_item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] drawn_value;
		logic                      draw_status;
	} draw_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] lower;
		logic [VALUE_W-1:0] gap;
		logic [VALUE_W-1:0] mask;
		logic               equal;
		logic               full_range;
	} bounds_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [VALUE_W-1:0] probe;
		logic               last;
	} cmd_t;

	function automatic logic [VALUE_W-1:0] smear_right(input logic [VALUE_W-1:0] x);
		logic [VALUE_W-1:0] y;
		y = x;
		y = y | (y >> 1);
		y = y | (y >> 2);
		y = y | (y >> 4);
		y = y | (y >> 8);
		y = y | (y >> 16);
		y = y | (y >> 32);
		return y;
	endfunction

endpackage

[rtl/core/bifbs_cfg.sv]
// Bound registers and the gap, mask and range flags derived from them.
module bifbs_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic [bifbs_pkg::VALUE_W-1:0]      cfg_data,
	output bifbs_pkg::bounds_t                 bounds
);

	logic [bifbs_pkg::VALUE_W-1:0] lower_q;
	logic [bifbs_pkg::VALUE_W-1:0] upper_q;
	logic [bifbs_pkg::VALUE_W-1:0] gap_q;
	logic [bifbs_pkg::VALUE_W-1:0] mask_q;
	logic                          equal_q;
	logic                          full_q;
	logic [bifbs_pkg::VALUE_W-1:0] lower_d;
	logic [bifbs_pkg::VALUE_W-1:0] upper_d;
	logic [bifbs_pkg::VALUE_W-1:0] gap_d;

	always_comb begin
		lower_d = (cfg_index == bifbs_pkg::REG_LOWER) ? cfg_data : lower_q;
		upper_d = (cfg_index == bifbs_pkg::REG_UPPER) ? cfg_data : upper_q;
		gap_d = upper_d - lower_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= bifbs_pkg::LOWER_RESET;
			upper_q <= bifbs_pkg::UPPER_RESET;
			gap_q <= bifbs_pkg::UPPER_RESET - bifbs_pkg::LOWER_RESET;
			mask_q <= bifbs_pkg::smear_right(bifbs_pkg::UPPER_RESET - bifbs_pkg::LOWER_RESET);
			equal_q <= 1'b0;
			full_q <= 1'b0;
		end else if (cfg_we) begin
			lower_q <= lower_d;
			upper_q <= upper_d;
			gap_q <= gap_d;
			mask_q <= bifbs_pkg::smear_right(gap_d);
			equal_q <= (upper_d == lower_d);
			full_q <= (lower_d == bifbs_pkg::INT64_MIN_BITS) &&
				(upper_d == bifbs_pkg::INT64_MAX_BITS);
		end
	end

	assign bounds.lower = lower_q;
	assign bounds.gap = gap_q;
	assign bounds.mask = mask_q;
	assign bounds.equal = equal_q;
	assign bounds.full_range = full_q;

endmodule

[rtl/core/bifbs_front.sv]
// Front end: assembles attempts byte by byte and issues commands to the back end.
module bifbs_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  bifbs_pkg::byte_item_t   byte_item,
	input  bifbs_pkg::bounds_t      bounds,
	output logic                    cmd_valid,
	output bifbs_pkg::cmd_t         cmd
);

	logic [bifbs_pkg::POS_W-1:0]   pos_q;
	logic [bifbs_pkg::LEN_W-1:0]   used_q;
	logic [bifbs_pkg::VALUE_W-1:0] asm_q;
	logic [bifbs_pkg::POS_W-1:0]   pos_inc;
	logic [bifbs_pkg::LEN_W-1:0]   used_new;
	logic [bifbs_pkg::VALUE_W-1:0] asm_new;
	logic                          take;
	logic                          done;
	logic                          clear;

	always_comb begin
		pos_inc = pos_q + 1'b1;
		take = (pos_q != '0) &&
			((pos_q - 1'b1) <= {{(bifbs_pkg::POS_W-bifbs_pkg::LEN_W){1'b0}}, used_q});
		if (pos_q == '0) begin
			used_new = byte_item.data_byte[bifbs_pkg::LEN_W-1:0];
			asm_new = '0;
		end else begin
			used_new = used_q;
			asm_new = take ? {asm_q[bifbs_pkg::VALUE_W-9:0], byte_item.data_byte} : asm_q;
		end
		done = (pos_inc == bifbs_pkg::ATTEMPT_BYTES);
		clear = bounds.equal || done || byte_item.end_of_data;

		cmd.probe = asm_new;
		cmd.last = byte_item.end_of_data;
		priority if (bounds.equal) begin
			cmd.kind = bifbs_pkg::KIND_EQUAL;
			cmd_valid = accept;
		end else if (done) begin
			cmd.kind = bifbs_pkg::KIND_JUDGE;
			cmd_valid = accept;
		end else begin
			cmd.kind = bifbs_pkg::KIND_END;
			cmd_valid = accept && byte_item.end_of_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			used_q <= '0;
			asm_q <= '0;
		end else if (accept) begin
			if (clear) begin
				pos_q <= '0;
				used_q <= '0;
				asm_q <= '0;
			end else begin
				pos_q <= pos_inc;
				used_q <= used_new;
				asm_q <= asm_new;
			end
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= bifbs_pkg::LAST_POS)
		else $error("Attempt position ran past the last byte.");

	a_equal_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && bounds.equal) |=> (pos_q == '0))
		else $error("Attempt not discarded under equal bounds.");

endmodule

[rtl/core/bifbs_queue.sv]
// Short command queue between the front end and the back end.
module bifbs_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  bifbs_pkg::cmd_t   wr_cmd,
	output logic              full,
	input  logic              rd_en,
	output logic              rd_valid,
	output bifbs_pkg::cmd_t   rd_cmd
);

	bifbs_pkg::cmd_t                mem_q [bifbs_pkg::Q_DEPTH];
	logic [bifbs_pkg::Q_PTR_W-1:0]  wr_ptr_q;
	logic [bifbs_pkg::Q_PTR_W-1:0]  rd_ptr_q;
	logic [bifbs_pkg::Q_CNT_W-1:0]  count_q;
	logic                           do_wr;
	logic                           do_rd;

	assign full = (count_q == bifbs_pkg::Q_CNT_W'(bifbs_pkg::Q_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_cmd = mem_q[rd_ptr_q];
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == bifbs_pkg::Q_PTR_W'(bifbs_pkg::Q_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == bifbs_pkg::Q_PTR_W'(bifbs_pkg::Q_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_wr, do_rd})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= bifbs_pkg::Q_CNT_W'(bifbs_pkg::Q_DEPTH))
		else $error("Command queue count exceeds its depth.");

	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> (count_q == $past(count_q) + 1'b1))
		else $error("Command queue lost a written entry.");

endmodule

[rtl/core/bifbs_back.sv]
// Back end: masks and judges probes against the bounds and holds the result item.
module bifbs_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cmd_valid,
	input  bifbs_pkg::cmd_t         cmd,
	output logic                    cmd_take,
	input  bifbs_pkg::bounds_t      bounds,
	output logic                    empty,
	input  logic                    pop,
	output bifbs_pkg::draw_item_t   draw_item
);

	logic                          out_valid_q;
	bifbs_pkg::draw_item_t         out_q;
	bifbs_pkg::draw_item_t         res;
	logic                          has_res;
	logic [bifbs_pkg::VALUE_W-1:0] masked;
	logic [bifbs_pkg::VALUE_W-1:0] shifted;
	logic                          in_range;

	assign cmd_take = cmd_valid && (!out_valid_q || pop);

	always_comb begin
		masked = cmd.probe & bounds.mask;
		shifted = bounds.lower + masked;
		in_range = (masked <= bounds.gap);
		res.drawn_value = '0;
		res.draw_status = bifbs_pkg::STATUS_OK;
		has_res = 1'b0;
		unique case (cmd.kind)
			bifbs_pkg::KIND_EQUAL: begin
				res.drawn_value = bounds.lower;
				has_res = 1'b1;
			end
			bifbs_pkg::KIND_JUDGE: begin
				priority if (bounds.full_range) begin
					res.drawn_value = cmd.probe;
					has_res = 1'b1;
				end else if (in_range) begin
					res.drawn_value = shifted;
					has_res = 1'b1;
				end else if (cmd.last) begin
					res.draw_status = bifbs_pkg::STATUS_OUT_OF_DATA;
					has_res = 1'b1;
				end else begin
					has_res = 1'b0;
				end
			end
			default: begin
				res.draw_status = bifbs_pkg::STATUS_OUT_OF_DATA;
				has_res = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_take) begin
			out_valid_q <= has_res;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take && has_res) begin
			out_q <= res;
		end
	end

	assign empty = !out_valid_q;
	assign draw_item = out_q;

endmodule

[rtl/core/bounded_integer_from_byte_stream.sv]
// Top level of the bounded integer decoder over a byte stream.
//
//  channel   handshake        payload
//  bytes     push / full      byte_item  (data_byte, end_of_data)
//  draws     pop / empty      draw_item  (drawn_value, draw_status)
//  config    cfg_we           cfg_index, cfg_data (64 bits)
//
// One byte item is taken every cycle while full is low; full comes from the two-entry
// command queue between the front end and the back end.
// The byte that ends a draw is written into the command queue, and the back end then registers the draw.
// Reset clears the bounds to 0 and 255 and discards any attempt in progress.
// When pop stays low the result register and then the command queue fill and full rises.
module bounded_integer_from_byte_stream (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  bifbs_pkg::byte_item_t              byte_item,
	output logic                               empty,
	input  logic                               pop,
	output bifbs_pkg::draw_item_t              draw_item,
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic [bifbs_pkg::VALUE_W-1:0]      cfg_data
);

	bifbs_pkg::bounds_t bounds;
	bifbs_pkg::cmd_t    front_cmd;
	bifbs_pkg::cmd_t    back_cmd;
	logic               front_valid;
	logic               back_valid;
	logic               back_take;
	logic               accept;

	assign accept = push && !full;

	bifbs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.bounds    (bounds)
	);

	bifbs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.byte_item (byte_item),
		.bounds    (bounds),
		.cmd_valid (front_valid),
		.cmd       (front_cmd)
	);

	bifbs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (front_valid),
		.wr_cmd   (front_cmd),
		.full     (full),
		.rd_en    (back_take),
		.rd_valid (back_valid),
		.rd_cmd   (back_cmd)
	);

	bifbs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (back_valid),
		.cmd       (back_cmd),
		.cmd_take  (back_take),
		.bounds    (bounds),
		.empty     (empty),
		.pop       (pop),
		.draw_item (draw_item)
	);

endmodule
